@@ rtl/dhd_pkg.sv @@
// Shared types, widths, register indexes and reset values for the detection head decoder.
// No dependencies; every other file of the block imports this package.
package dhd_pkg;

  localparam int FIELD_W         = 32;
  localparam int CLASS_W         = 7;
  localparam int FRAC_BITS       = 16;
  localparam int CLASS_COUNT_W   = 8;
  localparam int MODE_W          = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int DEF_MAX_CLASSES = 128;
  localparam int DEF_VALUE_WIDTH = 32;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Format modes; the unused code behaves like end-to-end.
  localparam mode_t MODE_RAW = 2'd0;
  localparam mode_t MODE_OBJ = 2'd1;
  localparam mode_t MODE_E2E = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t REG_FORMAT_MODE     = 2'd0;
  localparam cfg_idx_t REG_CLASS_COUNT     = 2'd1;
  localparam cfg_idx_t REG_SCORE_THRESHOLD = 2'd2;

  localparam mode_t                     RST_FORMAT_MODE = MODE_RAW;
  localparam logic [CLASS_COUNT_W-1:0]  RST_CLASS_COUNT = 8'd80;
  localparam logic signed [FIELD_W-1:0] RST_THRESHOLD   = 32'sd16384;

  localparam logic [CLASS_W-1:0] CLASS_MAX = 7'd127;

  // One finished anchor row, as handed from the row tracker to the scoring stages.
  // Values are sign-extended from the configured value width.
  typedef struct packed {
    logic signed [FIELD_W-1:0] box0;
    logic signed [FIELD_W-1:0] box1;
    logic signed [FIELD_W-1:0] box2;
    logic signed [FIELD_W-1:0] box3;
    logic signed [FIELD_W-1:0] obj;
    logic signed [FIELD_W-1:0] best;
    logic [CLASS_W-1:0]        cls;
    logic                      is_obj;
    logic                      is_e2e;
  } row_rec_t;

  // One detection as it leaves the block.
  typedef struct packed {
    logic signed [FIELD_W-1:0] box_x;
    logic signed [FIELD_W-1:0] box_y;
    logic signed [FIELD_W-1:0] box_width;
    logic signed [FIELD_W-1:0] box_height;
    logic signed [FIELD_W-1:0] confidence;
    logic [CLASS_W-1:0]        class_index;
  } det_t;

endpackage

@@ rtl/dhd_feat_if.sv @@
// Valid/ready channel interfaces for feature words in and detection words out.
// Depends on dhd_pkg for field widths.
interface dhd_feat_if;
  import dhd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] feature_value;

  modport source (output valid, output feature_value, input ready);
  modport sink   (input valid, input feature_value, output ready);
endinterface

interface dhd_det_if;
  import dhd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] box_x;
  logic signed [FIELD_W-1:0] box_y;
  logic signed [FIELD_W-1:0] box_width;
  logic signed [FIELD_W-1:0] box_height;
  logic signed [FIELD_W-1:0] confidence;
  logic [CLASS_W-1:0]        class_index;

  modport source (output valid, output box_x, output box_y, output box_width,
                  output box_height, output confidence, output class_index,
                  input ready);
  modport sink   (input valid, input box_x, input box_y, input box_width,
                  input box_height, input confidence, input class_index,
                  output ready);
endinterface

@@ rtl/dhd_row_tracker.sv @@
// Row tracker: position within the anchor row, box store, objectness and running best class.
// Depends on dhd_pkg. Emits one registered row record on the row's last word.
module dhd_row_tracker #(
  parameter int MAX_CLASSES = dhd_pkg::DEF_MAX_CLASSES,
  parameter int VALUE_WIDTH = dhd_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                word_valid,
  input  logic signed [VALUE_WIDTH-1:0]       word_value,
  input  logic                                restart,
  input  dhd_pkg::mode_t                      format_mode,
  input  logic [dhd_pkg::CLASS_COUNT_W-1:0]   class_count,
  output logic                                rec_valid_r,
  output dhd_pkg::row_rec_t                   rec_r
);
  import dhd_pkg::*;

  localparam int POS_W = $clog2(MAX_CLASSES + 6);
  localparam int CC_W  = CLASS_COUNT_W + 1;
  localparam int EXT_W = POS_W + CLASS_W;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic signed [VALUE_WIDTH-1:0] box_r [4];
  logic signed [VALUE_WIDTH-1:0] obj_r;
  logic signed [VALUE_WIDTH-1:0] best_r, best_nxt;
  logic [CLASS_W-1:0]            cls_r, cls_nxt;

  logic [CC_W-1:0]               cc_ext, cc_eff;
  logic [POS_W-1:0]              row_len, p, idx;
  logic [EXT_W-1:0]              idx_ext;
  logic [CLASS_W-1:0]            idx_sat, e2e_cls;
  logic                          is_raw, is_obj, is_e2e, is_score, last;
  logic signed [VALUE_WIDTH-1:0] cur_best;
  logic [CLASS_W-1:0]            cur_cls;
  logic signed [FIELD_W-1:0]     v_ext;
  logic                          take;

  assign take   = adv && word_valid;
  assign is_raw = (format_mode == MODE_RAW);
  assign is_obj = (format_mode == MODE_OBJ);
  assign is_e2e = !is_raw && !is_obj;

  // Effective class count clamped to 1..MAX_CLASSES.
  always_comb begin
    cc_ext = {1'b0, class_count};
    if (cc_ext == '0) begin
      cc_eff = CC_W'(1);
    end else if (cc_ext > CC_W'(MAX_CLASSES)) begin
      cc_eff = CC_W'(MAX_CLASSES);
    end else begin
      cc_eff = cc_ext;
    end
  end

  always_comb begin
    if (is_raw) begin
      row_len = POS_W'(cc_eff) + POS_W'(4);
    end else if (is_obj) begin
      row_len = POS_W'(cc_eff) + POS_W'(5);
    end else begin
      row_len = POS_W'(6);
    end
  end

  assign p    = (pos_r >= row_len) ? '0 : pos_r;
  assign last = ((p + POS_W'(1)) >= row_len);

  // Class scores follow the box words, and the objectness word in objectness mode.
  assign is_score = (p >= POS_W'(4)) && !is_e2e && !(is_obj && (p == POS_W'(4)));
  assign idx      = p - (is_obj ? POS_W'(5) : POS_W'(4));
  assign idx_ext  = EXT_W'(idx);
  assign idx_sat  = (idx_ext > EXT_W'(CLASS_MAX)) ? CLASS_MAX : idx_ext[CLASS_W-1:0];

  assign cur_best = (p == '0) ? VAL_MIN : best_r;
  assign cur_cls  = (p == '0) ? '0 : cls_r;

  always_comb begin
    if (is_score && (word_value > cur_best)) begin
      best_nxt = word_value;
      cls_nxt  = idx_sat;
    end else begin
      best_nxt = cur_best;
      cls_nxt  = cur_cls;
    end
  end

  // End-to-end class word: integer part, truncated toward zero, clamped to 0..127.
  assign v_ext = FIELD_W'(word_value);
  always_comb begin
    if (v_ext[FIELD_W-1]) begin
      e2e_cls = '0;
    end else if (|v_ext[FIELD_W-2:FRAC_BITS+CLASS_W]) begin
      e2e_cls = CLASS_MAX;
    end else begin
      e2e_cls = v_ext[FRAC_BITS +: CLASS_W];
    end
  end

  assign pos_nxt = last ? '0 : (p + POS_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      best_r      <= VAL_MIN;
      cls_r       <= '0;
      obj_r       <= '0;
      box_r       <= '{default: '0};
      rec_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        rec_valid_r <= word_valid && last && !restart;
      end
      if (restart) begin
        pos_r  <= '0;
        best_r <= VAL_MIN;
        cls_r  <= '0;
      end else if (take) begin
        pos_r  <= pos_nxt;
        best_r <= best_nxt;
        cls_r  <= cls_nxt;
        if (p < POS_W'(4)) begin
          box_r[p[1:0]] <= word_value;
        end
        if ((p == POS_W'(4)) && !is_raw) begin
          obj_r <= word_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      rec_r.box0   <= FIELD_W'(box_r[0]);
      rec_r.box1   <= FIELD_W'(box_r[1]);
      rec_r.box2   <= FIELD_W'(box_r[2]);
      rec_r.box3   <= FIELD_W'(box_r[3]);
      rec_r.obj    <= FIELD_W'(obj_r);
      rec_r.best   <= FIELD_W'(best_nxt);
      rec_r.cls    <= is_e2e ? e2e_cls : cls_nxt;
      rec_r.is_obj <= is_obj;
      rec_r.is_e2e <= is_e2e;
    end
  end

endmodule

@@ rtl/dhd_scorer.sv @@
// Scoring stages: objectness product, end-to-end box size, threshold gating, result register.
// Depends on dhd_pkg; takes row records from dhd_row_tracker.
module dhd_scorer #(
  parameter int VALUE_WIDTH = dhd_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  rec_valid,
  input  dhd_pkg::row_rec_t                     rec,
  input  logic signed [dhd_pkg::FIELD_W-1:0]    threshold,
  output logic                                  det_valid_r,
  output dhd_pkg::det_t                         det_r
);
  import dhd_pkg::*;

  localparam int PROD_W = 2 * VALUE_WIDTH;
  localparam int Q_W    = PROD_W - FRAC_BITS;
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN  = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH:0]   DIFF_MAX = {2'b00, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH:0]   DIFF_MIN = {2'b11, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [Q_W-1:0] Q_MAX =
    {{(Q_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN =
    {{(Q_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

  // First stage: product, size differences and the gates that do not need the product.
  logic signed [VALUE_WIDTH-1:0] b0, b1, b2, b3, obj, best;
  logic signed [VALUE_WIDTH:0]   dw, dh;
  logic signed [VALUE_WIDTH-1:0] w_sat, h_sat;
  logic                          obj_ok, gate;

  logic                          s3_valid_r;
  logic signed [VALUE_WIDTH-1:0] s3_x_r, s3_y_r, s3_w_r, s3_h_r, s3_conf_r;
  logic signed [PROD_W-1:0]      s3_prod_r;
  logic [CLASS_W-1:0]            s3_cls_r;
  logic                          s3_use_prod_r, s3_gate_r;

  assign b0   = rec.box0[VALUE_WIDTH-1:0];
  assign b1   = rec.box1[VALUE_WIDTH-1:0];
  assign b2   = rec.box2[VALUE_WIDTH-1:0];
  assign b3   = rec.box3[VALUE_WIDTH-1:0];
  assign obj  = rec.obj[VALUE_WIDTH-1:0];
  assign best = rec.best[VALUE_WIDTH-1:0];

  assign dw = (VALUE_WIDTH+1)'(b2) - (VALUE_WIDTH+1)'(b0);
  assign dh = (VALUE_WIDTH+1)'(b3) - (VALUE_WIDTH+1)'(b1);

  always_comb begin
    if (dw > DIFF_MAX) begin
      w_sat = VAL_MAX;
    end else if (dw < DIFF_MIN) begin
      w_sat = VAL_MIN;
    end else begin
      w_sat = dw[VALUE_WIDTH-1:0];
    end
    if (dh > DIFF_MAX) begin
      h_sat = VAL_MAX;
    end else if (dh < DIFF_MIN) begin
      h_sat = VAL_MIN;
    end else begin
      h_sat = dh[VALUE_WIDTH-1:0];
    end
  end

  assign obj_ok = (FIELD_W'(obj) >= threshold);

  always_comb begin
    if (rec.is_e2e) begin
      gate = obj_ok && (b2 > b0) && (b3 > b1);
    end else if (rec.is_obj) begin
      gate = obj_ok;
    end else begin
      gate = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rec_valid) begin
      s3_x_r        <= b0;
      s3_y_r        <= b1;
      s3_w_r        <= rec.is_e2e ? w_sat : b2;
      s3_h_r        <= rec.is_e2e ? h_sat : b3;
      s3_conf_r     <= rec.is_e2e ? obj : best;
      s3_prod_r     <= PROD_W'(obj) * PROD_W'(best);
      s3_cls_r      <= rec.cls;
      s3_use_prod_r <= rec.is_obj;
      s3_gate_r     <= gate;
    end
  end

  // Second stage: floor shift of the product, saturation and the score threshold.
  logic signed [Q_W-1:0]         q;
  logic signed [VALUE_WIDTH-1:0] q_sat, conf;
  logic                          emit;

  assign q = s3_prod_r[PROD_W-1:FRAC_BITS];

  always_comb begin
    if (q > Q_MAX) begin
      q_sat = VAL_MAX;
    end else if (q < Q_MIN) begin
      q_sat = VAL_MIN;
    end else begin
      q_sat = q[VALUE_WIDTH-1:0];
    end
  end

  assign conf = s3_use_prod_r ? q_sat : s3_conf_r;
  assign emit = s3_gate_r && (FIELD_W'(conf) >= threshold);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_valid_r <= 1'b0;
    end else if (adv) begin
      det_valid_r <= s3_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid_r) begin
      det_r.box_x       <= FIELD_W'(s3_x_r);
      det_r.box_y       <= FIELD_W'(s3_y_r);
      det_r.box_width   <= FIELD_W'(s3_w_r);
      det_r.box_height  <= FIELD_W'(s3_h_r);
      det_r.confidence  <= FIELD_W'(conf);
      det_r.class_index <= s3_cls_r;
    end
  end

endmodule

@@ rtl/detection_head_decoder.sv @@
// Detection head decoder: one feature word per cycle in, at most one detection per anchor row.
// A row's last word passes the input register, row record and two scoring stages to the output.
// Throughput: one word per cycle; every stage holds one word and all stages advance together
// whenever the result register is empty or being taken.
// Reset (rst_n, synchronous, active low) restores the register defaults, empties the pipeline
// and starts a new row.
module detection_head_decoder #(
  parameter int MAX_CLASSES = dhd_pkg::DEF_MAX_CLASSES,
  parameter int VALUE_WIDTH = dhd_pkg::DEF_VALUE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dhd_feat_if.sink                        in_ch,
  dhd_det_if.source                       out_ch,
  input  logic                            cfg_we,
  input  dhd_pkg::cfg_idx_t               cfg_index,
  input  logic [dhd_pkg::FIELD_W-1:0]     cfg_data
);
  import dhd_pkg::*;

  // Configuration registers. A write to any of them also restarts the current row.
  mode_t                     format_mode_r;
  logic [CLASS_COUNT_W-1:0]  class_count_r;
  logic signed [FIELD_W-1:0] threshold_r;
  logic                      restart;

  assign restart = cfg_we && ((cfg_index == REG_FORMAT_MODE) ||
                              (cfg_index == REG_CLASS_COUNT) ||
                              (cfg_index == REG_SCORE_THRESHOLD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_mode_r <= RST_FORMAT_MODE;
      class_count_r <= RST_CLASS_COUNT;
      threshold_r   <= RST_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT_MODE:     format_mode_r <= cfg_data[MODE_W-1:0];
        REG_CLASS_COUNT:     class_count_r <= cfg_data[CLASS_COUNT_W-1:0];
        REG_SCORE_THRESHOLD: threshold_r   <= cfg_data;
        default:             ;
      endcase
    end
  end

  // The whole pipeline moves as one. It stops only while a detection sits in the
  // result register and the sink does not take it, so input is taken back to back.
  logic  adv;
  logic  det_valid;
  det_t  det;

  assign adv         = !det_valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Input register. Bits above the configured value width are dropped here; the kept bits are
  // treated as a signed fixed-point word with 16 fraction bits (Q16.16 at the default width).
  logic                          in_valid_r;
  logic signed [VALUE_WIDTH-1:0] in_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ch.valid) begin
      in_value_r <= in_ch.feature_value[VALUE_WIDTH-1:0];
    end
  end

  // Row tracking: box words, objectness and the first best class score. A finished
  // row leaves as one registered record.
  logic     rec_valid;
  row_rec_t rec;

  dhd_row_tracker #(
    .MAX_CLASSES (MAX_CLASSES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_row (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .word_valid  (in_valid_r),
    .word_value  (in_value_r),
    .restart     (restart),
    .format_mode (format_mode_r),
    .class_count (class_count_r),
    .rec_valid_r (rec_valid),
    .rec_r       (rec)
  );

  // Scoring: the objectness product is registered before it is shifted, saturated
  // and compared, so the multiply and the score compare sit in separate stages.
  dhd_scorer #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_score (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .rec_valid   (rec_valid),
    .rec         (rec),
    .threshold   (threshold_r),
    .det_valid_r (det_valid),
    .det_r       (det)
  );

  assign out_ch.valid       = det_valid;
  assign out_ch.box_x       = det.box_x;
  assign out_ch.box_y       = det.box_y;
  assign out_ch.box_width   = det.box_width;
  assign out_ch.box_height  = det.box_height;
  assign out_ch.confidence  = det.confidence;
  assign out_ch.class_index = det.class_index;

endmodule

@@ rtl/dhd_checker.sv @@
// Port-level checks for the detection head decoder, bound to its top level.
// Depends on dhd_pkg for field widths.
module dhd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dhd_pkg::FIELD_W-1:0]     out_box_x,
  input logic [dhd_pkg::FIELD_W-1:0]     out_confidence,
  input logic [dhd_pkg::CLASS_W-1:0]     out_class_index
);
  import dhd_pkg::*;

  // A detection that waits keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_box_x) &&
      $stable(out_confidence) && $stable(out_class_index))
    else $error("waiting detection changed");

  // Input is refused exactly while a detection is stuck in the result register.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

  // Rows are at least five words long, so two detections never leave back to back.
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("detections closer than a row allows");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("detection present after reset");

  // in_valid is part of the watched handshake; an accepted word never meets a stall.
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !(out_valid && !out_ready))
    else $error("word accepted while the pipeline is stalled");

endmodule

bind detection_head_decoder dhd_checker u_dhd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_box_x       (out_ch.box_x),
  .out_confidence  (out_ch.confidence),
  .out_class_index (out_ch.class_index)
);
